// ===== design/assert_macros.svh =====
// Assertion macros for the mount scanner checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FJM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mount scanner assertion failed");

// Check a property on every clock edge, reset included.
`define FJM_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mount scanner reset assertion failed");

`endif

// ===== design/fjm_pkg.sv =====
// Shared types, codes and constant tables of the flash journal mount scanner.
// Depends on nothing.
`default_nettype none
package fjm_pkg;

  localparam int NUM_BLOCKS      = 3;
  localparam int MIRROR_BYTES    = 32;
  localparam int MAX_BLOCK_BYTES = 16;
  localparam int HEADER_BYTES    = 8;
  localparam int SECTOR_BYTES    = 4096;
  localparam int SECT_SHIFT      = $clog2(SECTOR_BYTES);

  // function codes of an input word
  localparam logic [1:0] FN_START  = 2'd0;
  localparam logic [1:0] FN_BYTE   = 2'd1;
  localparam logic [1:0] FN_STATUS = 2'd2;
  localparam logic [1:0] FN_MIRROR = 2'd3;

  // result kinds
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_READ   = 3'd1;
  localparam logic [2:0] K_ERASE  = 3'd2;
  localparam logic [2:0] K_DONE   = 3'd3;
  localparam logic [2:0] K_MIRROR = 3'd4;

  localparam logic [1:0] OUT_FOUND   = 2'd0;
  localparam logic [1:0] OUT_REBUILT = 2'd1;
  localparam logic [1:0] OUT_NONE    = 2'd2;

  localparam logic [7:0]  MAG_ACTIVE  = 8'hAA;
  localparam logic [7:0]  MAG_HISTORY = 8'h0A;
  localparam logic [7:0]  MAG_CONT    = 8'h55;
  localparam logic [7:0]  MAG_INVALID = 8'h00;
  localparam logic [7:0]  MAG_ERASED  = 8'hFF;
  localparam logic [7:0]  CONT_ID     = 8'hA5;
  localparam logic [15:0] CONT_INST   = 16'hCAFE;
  localparam logic [15:0] CONT_ADDR   = 16'hDADA;
  localparam logic [15:0] CONT_CRC    = 16'h0CBC;
  localparam logic [15:0] MIRROR_JUMP = 16'h2000;

  typedef enum logic [1:0] {
    OP_START, OP_BYTE, OP_STATUS, OP_MIRROR
  } op_t;

  // classified input word held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] read_byte;
    logic       flash_ok;
    logic [4:0] mirror_index;
  } item_t;

  // queue head as seen by the execution side
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [4:0] blk_size(input logic [1:0] id);
    case (id)
      2'd0:    blk_size = 5'd8;
      2'd1:    blk_size = 5'd8;
      default: blk_size = 5'd16;
    endcase
  endfunction

  function automatic logic [4:0] blk_offset(input logic [1:0] id);
    case (id)
      2'd0:    blk_offset = 5'h00;
      2'd1:    blk_offset = 5'h08;
      default: blk_offset = 5'h10;
    endcase
  endfunction

  function automatic logic [7:0] blk_magic(input logic [1:0] id);
    case (id)
      2'd0:    blk_magic = 8'h1D;
      2'd1:    blk_magic = 8'hEE;
      default: blk_magic = 8'hCE;
    endcase
  endfunction

  function automatic logic [7:0] mirror_default(input logic [4:0] idx);
    case (idx)
      5'd0:    mirror_default = 8'h1D;
      5'd1:    mirror_default = 8'h01;
      5'd2:    mirror_default = 8'h00;
      5'd3:    mirror_default = 8'h01;
      5'd8:    mirror_default = 8'hEE;
      5'd16:   mirror_default = 8'hCE;
      default: mirror_default = 8'hFF;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/fjm_if.sv =====
// Valid/ready channel interfaces for the scanner's input and result words.
// Depends on nothing.
`default_nettype none
interface fjm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] read_byte;
  logic       flash_ok;
  logic [4:0] mirror_index;
  modport source (output valid, func, read_byte, flash_ok, mirror_index, input ready);
  modport sink (input valid, func, read_byte, flash_ok, mirror_index, output ready);
endinterface

interface fjm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] flash_address;
  logic [4:0]  byte_count;
  logic [7:0]  mirror_byte;
  logic [1:0]  outcome;
  modport source (output valid, kind, flash_address, byte_count, mirror_byte, outcome,
                  input ready);
  modport sink (input valid, kind, flash_address, byte_count, mirror_byte, outcome,
                output ready);
endinterface
`default_nettype wire

// ===== design/flash_journal_mount_scanner_unit.sv =====
// Flash journal mount scanner: header/block scan of a four-sector journal.
// Depends on fjm_pkg, fjm_in_if, fjm_out_if, fjm_front and fjm_back.
//
// Usage: words arrive on in_ch (func selects start, flash byte, flash status
// or mirror read). A start with flash_ok set (else a later good status word)
// issues the first 8-byte header read request on out_ch; the host then feeds
// the read bytes one word each. Each word gives at most one result: read
// request, sector erase request, scan finished (with next free data address
// and outcome) or a RAM mirror byte.
// A word taken from in_ch is registered in the queue, then executed from the
// queue head into the output register.
// Throughput: one word per cycle while out_ch takes results; the execution
// stage handles each whole word, including a 9x8 checksum multiply-accumulate.
// Reset (rst_n low, synchronous) empties the queue and output register and
// loads the default mirror contents. When out_ch stalls, the output register
// holds its result, the execution stage stops and the two-entry queue takes
// up to two more words before in_ch.ready falls.
`default_nettype none
module flash_journal_mount_scanner_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fjm_in_if.sink      in_ch,
  fjm_out_if.source   out_ch
);
  import fjm_pkg::*;

  head_t head;
  logic  pop;

  fjm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_func         (in_ch.func),
    .in_read_byte    (in_ch.read_byte),
    .in_flash_ok     (in_ch.flash_ok),
    .in_mirror_index (in_ch.mirror_index),
    .head            (head),
    .pop             (pop)
  );

  fjm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_flash_address (out_ch.flash_address),
    .out_byte_count    (out_ch.byte_count),
    .out_mirror_byte   (out_ch.mirror_byte),
    .out_outcome       (out_ch.outcome)
  );
endmodule
`default_nettype wire

// ===== design/fjm_front.sv =====
// Front side: accepts input words, classifies them and holds them in a
// two-entry queue. Depends on fjm_pkg.
`default_nettype none
module fjm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_func,
  input  wire logic [7:0]    in_read_byte,
  input  wire logic          in_flash_ok,
  input  wire logic [4:0]    in_mirror_index,
  output fjm_pkg::head_t     head,
  input  wire logic          pop
);
  import fjm_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push;

  always_comb begin
    unique case (in_func)
      FN_START:  cls.op = OP_START;
      FN_BYTE:   cls.op = OP_BYTE;
      FN_STATUS: cls.op = OP_STATUS;
      default:   cls.op = OP_MIRROR;
    endcase
    cls.read_byte    = in_read_byte;
    cls.flash_ok     = in_flash_ok;
    cls.mirror_index = in_mirror_index;
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/fjm_back.sv =====
// Back side: runs the journal scan on one queued word per cycle unless a
// held result stalls, and holds results in an output register. Depends on fjm_pkg.
`default_nettype none
module fjm_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  fjm_pkg::head_t      head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          out_kind,
  output logic [15:0]         out_flash_address,
  output logic [4:0]          out_byte_count,
  output logic [7:0]          out_mirror_byte,
  output logic [1:0]          out_outcome
);
  import fjm_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_ERASE  = 3'd3;
  localparam logic [2:0] PH_WAIT   = 3'd4;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_HEADER  = 2'd1;
  localparam logic [1:0] ACT_CORRUPT = 2'd2;
  localparam logic [1:0] ACT_REPAIR  = 2'd3;

  localparam logic [15:0] FIRST_DATA = 16'(SECTOR_BYTES);

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  sector_r, sector_nxt;
  logic [15:0] hdr_addr_r, hdr_addr_nxt;
  logic [15:0] next_addr_r, next_addr_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  dbuf_r [MAX_BLOCK_BYTES];
  logic [7:0]  dbuf_nxt [MAX_BLOCK_BYTES];
  logic [7:0]  mirror_r [MIRROR_BYTES];
  logic [7:0]  mirror_nxt [MIRROR_BYTES];
  logic [1:0]  status_r [NUM_BLOCKS];
  logic [1:0]  status_nxt [NUM_BLOCKS];
  logic [15:0] inst_r [NUM_BLOCKS];
  logic [15:0] inst_nxt [NUM_BLOCKS];
  logic        found_r, found_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [7:0]  mb_r, mb_nxt;
  logic [1:0]  oc_r, oc_nxt;

  item_t       it;
  logic [1:0]  act;
  logic        emit;
  logic [63:0] w;
  logic [7:0]  f_magic, f_id;
  logic [15:0] f_inst, f_addr, f_crc;
  logic [1:0]  id2;
  logic [4:0]  size;
  logic [15:0] prod;
  logic [4:0]  cnt_inc;

  assign pop = head.valid && (!ov_r || out_ready);
  assign it  = head.item;

  always_comb begin
    phase_nxt     = phase_r;
    sector_nxt    = sector_r;
    hdr_addr_nxt  = hdr_addr_r;
    next_addr_nxt = next_addr_r;
    cnt_nxt       = cnt_r;
    hdr_nxt       = hdr_r;
    acc_nxt       = acc_r;
    dbuf_nxt      = dbuf_r;
    mirror_nxt    = mirror_r;
    status_nxt    = status_r;
    inst_nxt      = inst_r;
    found_nxt     = found_r;
    act           = ACT_NONE;
    emit          = 1'b0;
    kind_nxt      = K_NONE;
    addr_nxt      = 16'd0;
    bc_nxt        = 5'd0;
    mb_nxt        = 8'd0;
    oc_nxt        = OUT_NONE;
    cnt_inc       = cnt_r + 5'd1;
    w             = hdr_r;
    if (cnt_r < 5'(HEADER_BYTES)) w[{cnt_r[2:0], 3'b000} +: 8] = it.read_byte;
    f_magic = w[7:0];
    f_id    = w[15:8];
    f_inst  = w[31:16];
    f_addr  = w[47:32];
    f_crc   = w[63:48];
    id2     = hdr_r[9:8];
    size    = blk_size(id2);
    prod    = 16'(({1'b0, it.read_byte} + {4'd0, cnt_r}) * {1'b0, it.read_byte});

    if (pop) begin
      case (it.op)
        OP_START: begin
          phase_nxt     = PH_IDLE;
          sector_nxt    = 2'd0;
          hdr_addr_nxt  = 16'd0;
          next_addr_nxt = FIRST_DATA;
          cnt_nxt       = 5'd0;
          hdr_nxt       = 64'd0;
          acc_nxt       = 16'd0;
          for (int i = 0; i < MIRROR_BYTES; i++) mirror_nxt[i] = mirror_default(5'(i));
          for (int i = 0; i < NUM_BLOCKS; i++) begin
            status_nxt[i] = 2'd0;
            inst_nxt[i]   = 16'd0;
          end
          found_nxt = 1'b0;
          if (it.flash_ok) act = ACT_HEADER;
          else phase_nxt = PH_WAIT;
        end
        OP_MIRROR: begin
          emit     = 1'b1;
          kind_nxt = K_MIRROR;
          mb_nxt   = mirror_r[it.mirror_index];
        end
        OP_STATUS: begin
          if (it.flash_ok && phase_r == PH_WAIT) begin
            act = ACT_HEADER;
          end else if (it.flash_ok && phase_r == PH_ERASE) begin
            emit = 1'b1;
            if (sector_r != 2'd3) begin
              sector_nxt   = sector_r + 2'd1;
              hdr_addr_nxt = 16'(sector_r + 2'd1) << SECT_SHIFT;
              kind_nxt     = K_ERASE;
              addr_nxt     = hdr_addr_nxt;
            end else begin
              sector_nxt   = 2'd0;
              hdr_addr_nxt = 16'd0;
              phase_nxt    = PH_IDLE;
              kind_nxt     = K_DONE;
              addr_nxt     = next_addr_r;
              oc_nxt       = OUT_REBUILT;
            end
          end
        end
        default: begin
          if (phase_r == PH_HEADER) begin
            hdr_nxt = w;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= 5'(HEADER_BYTES)) begin
              // decode the completed header
              if (f_magic == MAG_ACTIVE || f_magic == MAG_HISTORY) begin
                if (f_addr[15:SECT_SHIFT] == hdr_addr_r[15:SECT_SHIFT] &&
                    f_id < 8'(NUM_BLOCKS)) begin
                  phase_nxt = PH_DATA;
                  cnt_nxt   = 5'd0;
                  acc_nxt   = f_inst + f_addr + {8'd0, f_id};
                  emit      = 1'b1;
                  kind_nxt  = K_READ;
                  addr_nxt  = f_addr;
                  bc_nxt    = blk_size(f_id[1:0]);
                end else begin
                  act = ACT_CORRUPT;
                end
              end else if (f_magic == MAG_CONT) begin
                if (!sector_r[0] && f_id == CONT_ID && f_inst == CONT_INST &&
                    f_addr == CONT_ADDR && f_crc == CONT_CRC) begin
                  sector_nxt    = sector_r + 2'd1;
                  hdr_addr_nxt  = 16'(sector_r + 2'd1) << SECT_SHIFT;
                  next_addr_nxt = 16'({1'b0, sector_r} + 3'd2) << SECT_SHIFT;
                  act           = ACT_HEADER;
                end else begin
                  act = ACT_CORRUPT;
                end
              end else if (f_magic == MAG_INVALID) begin
                hdr_addr_nxt = hdr_addr_r + 16'(HEADER_BYTES);
                act          = ACT_HEADER;
              end else if (f_magic == MAG_ERASED) begin
                if (found_r) begin
                  phase_nxt = PH_IDLE;
                  emit      = 1'b1;
                  kind_nxt  = K_DONE;
                  addr_nxt  = next_addr_r;
                  oc_nxt    = OUT_FOUND;
                end else if (sector_r != 2'd3) begin
                  sector_nxt   = sector_r + 2'd1;
                  hdr_addr_nxt = 16'(sector_r + 2'd1) << SECT_SHIFT;
                  act          = ACT_HEADER;
                end else begin
                  act = ACT_REPAIR;
                end
              end else begin
                act = ACT_CORRUPT;
              end
            end
          end else if (phase_r == PH_DATA) begin
            dbuf_nxt[cnt_r[3:0]] = it.read_byte;
            acc_nxt = acc_r + prod;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= size) begin
              // block complete: check magic and checksum, then copy
              if (dbuf_nxt[0] == blk_magic(id2) && acc_nxt == hdr_r[63:48]) begin
                for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
                  if (5'(i) < size) mirror_nxt[blk_offset(id2) + 5'(i)] = dbuf_nxt[i];
                end
                found_nxt       = 1'b1;
                status_nxt[id2] = 2'd1;
                inst_nxt[id2]   = hdr_r[31:16];
                next_addr_nxt   = hdr_r[47:32];
                hdr_addr_nxt    = hdr_addr_r + 16'(HEADER_BYTES);
                act             = ACT_HEADER;
              end else begin
                act = ACT_CORRUPT;
              end
            end
          end
        end
      endcase

      // fall over to the mirror sectors, or rebuild once they are used up
      if (act == ACT_CORRUPT) begin
        if (!sector_r[1]) begin
          sector_nxt   = sector_r + 2'd2;
          hdr_addr_nxt = hdr_addr_r + MIRROR_JUMP;
          act          = ACT_HEADER;
        end else begin
          act = ACT_REPAIR;
        end
      end
      if (act == ACT_REPAIR) begin
        sector_nxt    = 2'd0;
        hdr_addr_nxt  = 16'd0;
        next_addr_nxt = FIRST_DATA;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          inst_nxt[i] = 16'd0;
          if (status_r[i] == 2'd1) status_nxt[i] = 2'd2;
        end
        phase_nxt = PH_ERASE;
        emit      = 1'b1;
        kind_nxt  = K_ERASE;
        addr_nxt  = 16'd0;
      end
      if (act == ACT_HEADER) begin
        phase_nxt = PH_HEADER;
        cnt_nxt   = 5'd0;
        hdr_nxt   = 64'd0;
        emit      = 1'b1;
        kind_nxt  = K_READ;
        addr_nxt  = hdr_addr_nxt;
        bc_nxt    = 5'(HEADER_BYTES);
      end
    end

    if (pop && emit) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
    else ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    hdr_r    <= hdr_nxt;
    acc_r    <= acc_nxt;
    dbuf_r   <= dbuf_nxt;
    inst_r   <= inst_nxt;
    if (pop && emit) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      bc_r   <= bc_nxt;
      mb_r   <= mb_nxt;
      oc_r   <= oc_nxt;
    end
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sector_r    <= 2'd0;
      hdr_addr_r  <= 16'd0;
      next_addr_r <= FIRST_DATA;
      cnt_r       <= 5'd0;
      found_r     <= 1'b0;
      ov_r        <= 1'b0;
      for (int i = 0; i < MIRROR_BYTES; i++) mirror_r[i] <= mirror_default(5'(i));
      for (int i = 0; i < NUM_BLOCKS; i++) status_r[i] <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      sector_r    <= sector_nxt;
      hdr_addr_r  <= hdr_addr_nxt;
      next_addr_r <= next_addr_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      ov_r        <= ov_nxt;
      mirror_r    <= mirror_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = kind_r;
  assign out_flash_address = addr_r;
  assign out_byte_count    = bc_r;
  assign out_mirror_byte   = mb_r;
  assign out_outcome       = oc_r;
endmodule
`default_nettype wire

// ===== design/fjm_checker.sv =====
// Port-level checker for the mount scanner, bound to the top level.
// Depends on fjm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fjm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [15:0] out_flash_address,
  input wire logic [4:0]  out_byte_count,
  input wire logic [7:0]  out_mirror_byte,
  input wire logic [1:0]  out_outcome
);
  import fjm_pkg::*;

  // hold a stalled result
  `FJM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_flash_address))
  // unused fields stay at their neutral values
  `FJM_ASSERT(a_read_shape, clk, rst_n, out_valid && out_kind == K_READ |-> (out_byte_count == 5'd8 || out_byte_count == 5'd16) && out_outcome == OUT_NONE && out_mirror_byte == 8'd0)
  `FJM_ASSERT(a_done_shape, clk, rst_n, out_valid && out_kind == K_DONE |-> (out_outcome == OUT_FOUND || out_outcome == OUT_REBUILT) && out_byte_count == 5'd0)
  // erase requests land on sector boundaries
  `FJM_ASSERT(a_erase_align, clk, rst_n, out_valid && out_kind == K_ERASE |-> out_flash_address[SECT_SHIFT-1:0] == '0 && out_byte_count == 5'd0)
  `FJM_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)
endmodule

bind flash_journal_mount_scanner_unit fjm_checker u_fjm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_flash_address (out_ch.flash_address),
  .out_byte_count    (out_ch.byte_count),
  .out_mirror_byte   (out_ch.mirror_byte),
  .out_outcome       (out_ch.outcome)
);
`default_nettype wire

// ===== bench/fjm_scan_checker.sv =====
// Checker for the flash journal mount scanner: watches both channels, keeps its
// own model of the scan, and compares every result word. Depends on fjm_pkg, fjm_if.
module fjm_scan_checker (
  input  logic clk,
  input  logic rst_n,
  fjm_in_if    in_ch,
  fjm_out_if   out_ch,
  output int   fail_count,
  output int   results_seen,
  output int   results_owed
);
  import fjm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {S_IDLE, S_HEADER, S_DATA, S_ERASE, S_WAIT} scan_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] flash_address;
    logic [4:0]  byte_count;
    logic [7:0]  mirror_byte;
    logic [1:0]  outcome;
  } scan_result_t;

  localparam logic [7:0] BLK_MAGIC [3] = '{8'h1D, 8'hEE, 8'hCE};
  localparam logic [4:0] BLK_SIZE [3] = '{5'd8, 5'd8, 5'd16};
  localparam logic [4:0] BLK_BASE [3] = '{5'h00, 5'h08, 5'h10};

  scan_result_t pending_results[$];

  scan_t       scan_phase;
  logic [1:0]  cur_sector;
  logic [15:0] hdr_addr;
  logic [15:0] free_addr;
  logic [4:0]  byte_pos;
  logic [63:0] hdr_word;
  logic [15:0] csum;
  logic [7:0]  blk_buf [16];
  logic [7:0]  mirror [32];
  logic        found_any;

  assign results_owed = pending_results.size();

  function automatic logic [7:0] default_mirror(int idx);
    case (idx)
      0:       return 8'h1D;
      1:       return 8'h01;
      2:       return 8'h00;
      3:       return 8'h01;
      8:       return 8'hEE;
      16:      return 8'hCE;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic push_result(logic [2:0] k, logic [15:0] a, logic [4:0] c,
                             logic [7:0] m, logic [1:0] o);
    pending_results.push_back('{k, a, c, m, o});
  endtask

  task automatic wipe_state();
    scan_phase = S_IDLE;
    cur_sector = 0;
    hdr_addr = 0;
    free_addr = 16'h1000;
    byte_pos = 0;
    hdr_word = 0;
    csum = 0;
    found_any = 0;
    for (int i = 0; i < 16; i++) blk_buf[i] = 8'h00;
    for (int i = 0; i < 32; i++) mirror[i] = default_mirror(i);
  endtask

  task automatic ask_header();
    scan_phase = S_HEADER;
    byte_pos = 0;
    hdr_word = 0;
    push_result(K_READ, hdr_addr, 5'd8, 8'h00, OUT_NONE);
  endtask

  task automatic begin_repair();
    cur_sector = 0;
    hdr_addr = 0;
    free_addr = 16'h1000;
    scan_phase = S_ERASE;
    push_result(K_ERASE, hdr_addr, 5'd0, 8'h00, OUT_NONE);
  endtask

  task automatic fall_over();
    if (cur_sector < 2) begin
      cur_sector = cur_sector + 2'd2;
      hdr_addr = hdr_addr + 16'h2000;
      ask_header();
    end else begin
      begin_repair();
    end
  endtask

  task automatic decode_header();
    logic [7:0]  magic;
    logic [7:0]  id;
    logic [15:0] inst;
    logic [15:0] addr;
    logic [15:0] crc;
    magic = hdr_word[7:0];
    id = hdr_word[15:8];
    inst = hdr_word[31:16];
    addr = hdr_word[47:32];
    crc = hdr_word[63:48];
    case (magic)
      MAG_ACTIVE, MAG_HISTORY: begin
        if (addr[15:12] == hdr_addr[15:12] && id < 3) begin
          scan_phase = S_DATA;
          byte_pos = 0;
          csum = inst + addr + {8'h00, id};
          push_result(K_READ, addr, BLK_SIZE[id], 8'h00, OUT_NONE);
        end else begin
          fall_over();
        end
      end
      MAG_CONT: begin
        if ((cur_sector == 0 || cur_sector == 2) && id == CONT_ID && inst == CONT_INST &&
            addr == CONT_ADDR && crc == CONT_CRC) begin
          cur_sector = cur_sector + 2'd1;
          hdr_addr = {2'b00, cur_sector, 12'h000};
          free_addr = ({14'd0, cur_sector} + 16'd1) << 12;
          ask_header();
        end else begin
          fall_over();
        end
      end
      MAG_INVALID: begin
        hdr_addr = hdr_addr + 16'd8;
        ask_header();
      end
      MAG_ERASED: begin
        if (found_any) begin
          scan_phase = S_IDLE;
          push_result(K_DONE, free_addr, 5'd0, 8'h00, OUT_FOUND);
        end else if (cur_sector < 3) begin
          cur_sector = cur_sector + 2'd1;
          hdr_addr = {2'b00, cur_sector, 12'h000};
          ask_header();
        end else begin
          begin_repair();
        end
      end
      default: fall_over();
    endcase
  endtask

  task automatic close_block();
    logic [7:0] id;
    id = hdr_word[15:8];
    if (id < 3 && blk_buf[0] == BLK_MAGIC[id] && csum == hdr_word[63:48]) begin
      for (int i = 0; i < BLK_SIZE[id]; i++) mirror[BLK_BASE[id] + i] = blk_buf[i];
      found_any = 1;
      free_addr = hdr_word[47:32];
      hdr_addr = hdr_addr + 16'd8;
      ask_header();
    end else begin
      fall_over();
    end
  endtask

  task automatic scan_step(logic [1:0] fn, logic [7:0] b, logic ok, logic [4:0] mi);
    logic [4:0]  size;
    logic [15:0] prod;
    case (fn)
      FN_START: begin
        wipe_state();
        if (!ok) scan_phase = S_WAIT;
        else ask_header();
      end
      FN_MIRROR: push_result(K_MIRROR, 16'h0000, 5'd0, mirror[mi], OUT_NONE);
      FN_STATUS: begin
        if (ok && scan_phase == S_WAIT) begin
          ask_header();
        end else if (ok && scan_phase == S_ERASE) begin
          if (cur_sector < 3) begin
            cur_sector = cur_sector + 2'd1;
            hdr_addr = {2'b00, cur_sector, 12'h000};
            push_result(K_ERASE, hdr_addr, 5'd0, 8'h00, OUT_NONE);
          end else begin
            cur_sector = 0;
            hdr_addr = 0;
            scan_phase = S_IDLE;
            push_result(K_DONE, free_addr, 5'd0, 8'h00, OUT_REBUILT);
          end
        end
      end
      default: begin
        if (scan_phase == S_HEADER) begin
          if (byte_pos < 8) hdr_word[8*byte_pos +: 8] = b;
          byte_pos = byte_pos + 5'd1;
          if (byte_pos >= 8) decode_header();
        end else if (scan_phase == S_DATA) begin
          size = BLK_SIZE[hdr_word[15:8]];
          if (byte_pos < 16) blk_buf[byte_pos[3:0]] = b;
          prod = ({8'h00, b} + {11'd0, byte_pos}) * {8'h00, b};
          csum = csum + prod;
          byte_pos = byte_pos + 5'd1;
          if (byte_pos >= size) close_block();
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    wipe_state();
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      wipe_state();
    end else begin
      if (in_ch.valid && in_ch.ready)
        scan_step(in_ch.func, in_ch.read_byte, in_ch.flash_ok, in_ch.mirror_index);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d", out_ch.kind));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
          if (out_ch.flash_address !== want.flash_address)
            flag_mismatch($sformatf("address %h, want %h", out_ch.flash_address,
                                    want.flash_address));
          if (out_ch.byte_count !== want.byte_count)
            flag_mismatch($sformatf("byte count %0d, want %0d", out_ch.byte_count,
                                    want.byte_count));
          if (out_ch.mirror_byte !== want.mirror_byte)
            flag_mismatch($sformatf("mirror byte %h, want %h", out_ch.mirror_byte,
                                    want.mirror_byte));
          if (out_ch.outcome !== want.outcome)
            flag_mismatch($sformatf("outcome %0d, want %0d", out_ch.outcome,
                                    want.outcome));
        end
      end
    end
  end

endmodule

// ===== bench/flash_journal_mount_scanner_unit_tb.sv =====
// Top of the mount scanner bench: clock, reset, journal stimulus, result sink
// and verdict. Depends on fjm_pkg, fjm_if, the scanner and fjm_scan_checker.
module flash_journal_mount_scanner_unit_tb;
  import fjm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 1400;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   words_sent = 0;
  int   fail_count;
  int   results_seen;
  int   results_owed;
  logic no_gaps = 1'b0;
  logic [3:0] guess_sector;

  logic [7:0] blk_magic_tab [3] = '{8'h1D, 8'hEE, 8'hCE};
  int         blk_len_tab [3] = '{8, 8, 16};

  fjm_in_if  in_ch();
  fjm_out_if out_ch();

  flash_journal_mount_scanner_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  fjm_scan_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .results_seen(results_seen), .results_owed(results_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, one quiet window
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cycles == 2500) begin
      out_ch.ready <= 1'b0;
      hold_left <= 300;
    end else if (cycles > 5000 && cycles < 6500) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 26);
    end
  end

  task automatic send_word(logic [1:0] fn, logic [7:0] b, logic ok, logic [4:0] mi);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.read_byte <= b;
    in_ch.flash_ok <= ok;
    in_ch.mirror_index <= mi;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    // drop valid for one cycle now and then
    if (!no_gaps && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(FN_BYTE, b, $urandom_range(1), $urandom_range(31));
  endtask

  task automatic send_status(logic ok);
    send_word(FN_STATUS, $urandom_range(255), ok, $urandom_range(31));
  endtask

  task automatic send_header(logic [7:0] magic, logic [7:0] id, logic [15:0] inst,
                             logic [15:0] addr, logic [15:0] crc);
    logic [63:0] w;
    w = {crc, addr, inst, id, magic};
    for (int i = 0; i < 8; i++) send_byte(w[8*i +: 8]);
  endtask

  // spoil: 0 clean, 1 wrong block magic, 2 wrong checksum, 3 address off-sector
  task automatic send_block(int id, int spoil);
    logic [7:0]  body [16];
    logic [15:0] inst;
    logic [15:0] addr;
    logic [15:0] crc;
    inst = $urandom;
    addr = {guess_sector ^ (spoil == 3 ? 4'h8 : 4'h0), 12'($urandom)};
    crc = inst + addr + 16'(id);
    for (int i = 0; i < blk_len_tab[id]; i++) begin
      body[i] = (i == 0 && spoil != 1) ? blk_magic_tab[id] : 8'($urandom);
      crc = crc + (16'(body[i]) + 16'(i)) * 16'(body[i]);
    end
    if (spoil == 2) crc = crc ^ 16'h0001;
    send_header($urandom_range(1) ? MAG_ACTIVE : MAG_HISTORY, 8'(id), inst, addr, crc);
    for (int i = 0; i < blk_len_tab[id]; i++) send_byte(body[i]);
  endtask

  task automatic send_cont();
    send_header(MAG_CONT, CONT_ID, CONT_INST, CONT_ADDR, CONT_CRC);
    guess_sector = guess_sector + 4'd1;
  endtask

  task automatic start_scan(logic ok);
    send_word(FN_START, $urandom_range(255), ok, $urandom_range(31));
    guess_sector = 0;
  endtask

  task automatic random_journal();
    int pick;
    start_scan($urandom_range(9) != 0);
    if ($urandom_range(3) == 0) send_status(1'b0);
    send_status(1'b1);
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(99);
      if (pick < 55) send_block($urandom_range(2), 0);
      else if (pick < 63) send_block($urandom_range(2), $urandom_range(1, 3));
      else if (pick < 70) send_header(MAG_INVALID, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 76) send_cont();
      else if (pick < 82) send_header($urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 92) send_word(FN_MIRROR, $urandom, $urandom_range(1),
                                     $urandom_range(31));
      else if (pick < 96) send_status($urandom_range(1));
      else send_byte($urandom);
    end
    // walk off the end: erased headers, then let any rebuild finish
    repeat ($urandom_range(1, 4)) send_header(MAG_ERASED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    if ($urandom_range(2) == 0) send_status(1'b0);
    repeat ($urandom_range(0, 5)) send_status(1'b1);
    repeat ($urandom_range(0, 3)) send_word(FN_MIRROR, $urandom, $urandom_range(1),
                                            $urandom_range(31));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_STATUS;
    in_ch.read_byte <= 8'h00;
    in_ch.flash_ok <= 1'b0;
    in_ch.mirror_index <= 5'd0;
    guess_sector = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle noise, waiting start, good blocks, skip, continuation, finish
    send_byte(8'hFF);
    send_status(1'b1);
    send_word(FN_MIRROR, 8'h00, 1'b0, 5'd0);
    send_word(FN_MIRROR, 8'hFF, 1'b1, 5'd31);
    start_scan(1'b0);
    send_status(1'b0);
    send_status(1'b1);
    send_block(0, 0);
    send_header(MAG_INVALID, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_block(2, 0);
    send_cont();
    send_block(1, 0);
    send_header(MAG_ERASED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(FN_MIRROR, 8'h5A, 1'b0, 5'd16);
    // start during a scan, then all sectors erased: rebuild with defaults
    start_scan(1'b1);
    send_byte(8'hAA);
    start_scan(1'b1);
    repeat (4) send_header(MAG_ERASED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_status(1'b0);
    repeat (4) send_status(1'b1);
    // corruption in working and mirror sectors
    start_scan(1'b1);
    send_block(0, 1);
    send_block(1, 2);
    repeat (4) send_status(1'b1);

    while (words_sent < WORD_TARGET) begin
      no_gaps = (words_sent > 700 && words_sent < 900);
      random_journal();
    end
    in_ch.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d words over random journals; checked %0d results.",
             words_sent, results_seen);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
